FILE: sv/vefm_pkg.sv
// Shared types, codes and defaults of the voxel exposed-face mask unit.
package vefm_pkg;

  localparam int SIDE_X_DEF = 32;
  localparam int SIDE_Y_DEF = 32;
  localparam int SIDE_Z_DEF = 32;

  localparam int COORD_W = 5;
  localparam int FACE_W  = 6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [FACE_W-1:0] FACE_POS_Z = 6'b000001;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 6'b000010;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 6'b000100;
  localparam logic [FACE_W-1:0] FACE_POS_X = 6'b001000;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 6'b010000;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 6'b100000;
  localparam logic [FACE_W-1:0] FACE_FULL  = 6'b111111;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic               fill;
  } in_item_t;

  typedef struct packed {
    logic [FACE_W-1:0] face_mask;
    logic              self_occupied;
  } out_item_t;

  typedef enum logic [2:0] {
    STEP_OWN,
    STEP_YM,
    STEP_YP,
    STEP_ZM,
    STEP_ZP
  } step_t;

  typedef struct packed {
    logic  init;
    logic  vld;
    logic  ok;
    step_t step;
  } row_ctl_t;

endpackage

FILE: sv/vefm_ram.sv
// Generic single-port RAM with registered read data.
module vefm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/vefm_mask.sv
// Folds occupancy rows returned by the memory into the face mask and own bit.
module vefm_mask #(
  parameter int SIDE_X = vefm_pkg::SIDE_X_DEF
) (
  input  logic                          clk,
  input  vefm_pkg::row_ctl_t            ctl,
  input  logic [vefm_pkg::COORD_W-1:0]  pos_x,
  input  logic [SIDE_X-1:0]             row,
  output logic [vefm_pkg::FACE_W-1:0]   face_mask,
  output logic                          self_occupied
);
  import vefm_pkg::*;

  localparam int XW = (SIDE_X > 1) ? $clog2(SIDE_X) : 1;

  logic [FACE_W-1:0]  mask_r;
  logic               self_r;
  logic [COORD_W:0]   xm;
  logic [COORD_W:0]   xp;
  logic [COORD_W:0]   xc;
  logic               b_own;
  logic               b_left;
  logic               b_right;

  function automatic logic row_bit(input logic [SIDE_X-1:0] r, input logic [COORD_W:0] idx);
    logic b;
    b = 1'b0;
    if (int'(idx) < SIDE_X) begin
      b = r[XW'(idx)];
    end
    return b;
  endfunction

  assign xc = {1'b0, pos_x};
  assign xm = xc - 1'b1;
  assign xp = xc + 1'b1;

  assign b_own   = row_bit(row, xc);
  assign b_left  = (pos_x != '0) && row_bit(row, xm);
  assign b_right = row_bit(row, xp);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      mask_r <= FACE_FULL;
      self_r <= 1'b0;
    end else if (ctl.vld && ctl.ok) begin
      unique case (ctl.step)
        STEP_OWN: begin
          self_r <= b_own;
          mask_r <= mask_r & ~(b_left ? FACE_NEG_X : '0) & ~(b_right ? FACE_POS_X : '0);
        end
        STEP_YM: if (b_own) mask_r <= mask_r & ~FACE_NEG_Y;
        STEP_YP: if (b_own) mask_r <= mask_r & ~FACE_POS_Y;
        STEP_ZM: if (b_own) mask_r <= mask_r & ~FACE_NEG_Z;
        STEP_ZP: if (b_own) mask_r <= mask_r & ~FACE_POS_Z;
        default: mask_r <= mask_r;
      endcase
    end
  end

  assign face_mask     = mask_r;
  assign self_occupied = self_r;

endmodule

FILE: sv/voxel_exposed_face_mask_unit.sv
// Top level of the voxel exposed-face mask unit.
// The occupancy grid is held one y/z row per word in a single-port memory of
// SIDE_Y*SIDE_Z words of SIDE_X bits. After reset a clearing pass zeroes one
// row a cycle, with in_ready low. A query makes five row reads through the
// single memory port (own row, y-1, y+1, z-1, z+1), then folds the last row
// in S_LAST and loads the output register in S_DONE; it waits in S_DONE only
// while an earlier result has not been taken. A write reads the row, then
// writes the modified row back. One item is worked on at a time; a new item
// is accepted while the previous result still waits.
module voxel_exposed_face_mask_unit #(
  parameter int SIDE_X = vefm_pkg::SIDE_X_DEF,
  parameter int SIDE_Y = vefm_pkg::SIDE_Y_DEF,
  parameter int SIDE_Z = vefm_pkg::SIDE_Z_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vefm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vefm_pkg::out_item_t out_data
);
  import vefm_pkg::*;

  localparam int DEPTH = SIDE_Y * SIDE_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (SIDE_X > 1) ? $clog2(SIDE_X) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WMOD,
    S_LAST,
    S_DONE
  } state_t;

  state_t              state_r;
  in_item_t            item_r;
  step_t               step_r;
  logic [AW-1:0]       clr_cnt_r;
  row_ctl_t            rdi_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                accept;
  logic [COORD_W:0]    yc;
  logic [COORD_W:0]    zc;
  logic [COORD_W:0]    ry;
  logic [COORD_W:0]    rz;
  logic                row_ok;
  logic                own_ok;
  logic [AW-1:0]       row_addr;
  logic                ram_en;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [SIDE_X-1:0]   ram_wdata;
  logic [SIDE_X-1:0]   ram_rdata;
  logic [SIDE_X-1:0]   row_mod;
  row_ctl_t            mask_ctl;
  logic [FACE_W-1:0]   face_mask;
  logic                self_occ;
  logic                x_in;

  assign accept = in_valid && in_ready;
  assign yc     = {1'b0, item_r.pos_y};
  assign zc     = {1'b0, item_r.pos_z};
  assign x_in   = int'(item_r.pos_x) < SIDE_X;
  assign own_ok = (int'(yc) < SIDE_Y) && (int'(zc) < SIDE_Z);

  always_comb begin
    ry     = yc;
    rz     = zc;
    row_ok = own_ok;
    unique case (step_r)
      STEP_OWN: begin
        row_ok = own_ok;
      end
      STEP_YM: begin
        ry     = yc - 1'b1;
        row_ok = (yc != '0) && (int'(yc) - 1 < SIDE_Y) && (int'(zc) < SIDE_Z);
      end
      STEP_YP: begin
        ry     = yc + 1'b1;
        row_ok = (int'(yc) + 1 < SIDE_Y) && (int'(zc) < SIDE_Z);
      end
      STEP_ZM: begin
        rz     = zc - 1'b1;
        row_ok = (zc != '0) && (int'(zc) - 1 < SIDE_Z) && (int'(yc) < SIDE_Y);
      end
      STEP_ZP: begin
        rz     = zc + 1'b1;
        row_ok = (int'(zc) + 1 < SIDE_Z) && (int'(yc) < SIDE_Y);
      end
      default: begin
        row_ok = 1'b0;
      end
    endcase
  end

  assign row_addr = AW'(int'(rz) * SIDE_Y + int'(ry));

  always_comb begin
    row_mod = ram_rdata;
    if (x_in) begin
      row_mod[XW'(item_r.pos_x)] = item_r.fill;
    end
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = row_addr;
    ram_wdata = row_mod;
    unique case (state_r)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = '0;
      end
      S_READ: begin
        ram_en = row_ok;
      end
      S_WMOD: begin
        ram_en = own_ok && x_in;
        ram_we = 1'b1;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= STEP_OWN;
      rdi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rdi_r.vld <= (state_r == S_READ);
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_data;
            step_r  <= STEP_OWN;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rdi_r.ok   <= row_ok;
          rdi_r.step <= step_r;
          if (item_r.command == CMD_WRITE) begin
            state_r <= S_WMOD;
          end else begin
            unique case (step_r)
              STEP_OWN: step_r <= STEP_YM;
              STEP_YM:  step_r <= STEP_YP;
              STEP_YP:  step_r <= STEP_ZM;
              STEP_ZM:  step_r <= STEP_ZP;
              default:  state_r <= S_LAST;
            endcase
          end
        end
        S_WMOD: begin
          state_r <= S_IDLE;
        end
        S_LAST: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.face_mask     <= face_mask;
            out_data_r.self_occupied <= self_occ;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    mask_ctl      = rdi_r;
    mask_ctl.init = accept;
    mask_ctl.vld  = rdi_r.vld && (item_r.command == CMD_QUERY);
  end

  vefm_ram #(
    .WIDTH (SIDE_X),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_occ_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  vefm_mask #(
    .SIDE_X (SIDE_X)
  ) u_mask (
    .clk           (clk),
    .ctl           (mask_ctl),
    .pos_x         (item_r.pos_x),
    .row           (ram_rdata),
    .face_mask     (face_mask),
    .self_occupied (self_occ)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/vefm_chk.sv
// Port-level checker for the voxel exposed-face mask unit, bound to the top level.
module vefm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input vefm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input vefm_pkg::out_item_t out_data
);
  import vefm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ports not quiet after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_WRITE |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("write produced a result");

endmodule

bind voxel_exposed_face_mask_unit vefm_chk u_vefm_chk (.*);

FILE: tb/sv/vefm_face_checker.sv
// Checker for the voxel exposed-face mask unit: grid predictor and result comparison.
module vefm_face_checker #(
  parameter int SIDE_X = vefm_pkg::SIDE_X_DEF,
  parameter int SIDE_Y = vefm_pkg::SIDE_Y_DEF,
  parameter int SIDE_Z = vefm_pkg::SIDE_Z_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  vefm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  vefm_pkg::out_item_t out_data,
  output int                  mismatch_count,
  output int                  results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import vefm_pkg::*;

  bit        voxel_occ [SIDE_Z][SIDE_Y][SIDE_X];
  out_item_t faces_due [$];

  function automatic bit occupied_at(int x, int y, int z);
    if (x < 0 || x >= SIDE_X || y < 0 || y >= SIDE_Y || z < 0 || z >= SIDE_Z)
      return 1'b0;
    return voxel_occ[z][y][x];
  endfunction

  function automatic out_item_t exposed_faces(int x, int y, int z);
    out_item_t r;
    r.face_mask = '0;
    if (!occupied_at(x, y, z + 1)) r.face_mask |= FACE_POS_Z;
    if (!occupied_at(x, y, z - 1)) r.face_mask |= FACE_NEG_Z;
    if (!occupied_at(x - 1, y, z)) r.face_mask |= FACE_NEG_X;
    if (!occupied_at(x + 1, y, z)) r.face_mask |= FACE_POS_X;
    if (!occupied_at(x, y + 1, z)) r.face_mask |= FACE_POS_Y;
    if (!occupied_at(x, y - 1, z)) r.face_mask |= FACE_NEG_Y;
    r.self_occupied = occupied_at(x, y, z);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t due;
    int        px;
    int        py;
    int        pz;
    if (!rst_n) begin
      foreach (voxel_occ[z, y, x]) voxel_occ[z][y][x] = 1'b0;
      faces_due.delete();
      mismatch_count = 0;
      results_due <= 0;
    end else begin
      if (in_valid && in_ready) begin
        px = int'(in_data.pos_x);
        py = int'(in_data.pos_y);
        pz = int'(in_data.pos_z);
        if (in_data.command == CMD_QUERY) begin
          faces_due.push_back(exposed_faces(px, py, pz));
        end else if (px < SIDE_X && py < SIDE_Y && pz < SIDE_Z) begin
          voxel_occ[pz][py][px] = in_data.fill;
        end
      end
      if (out_valid && out_ready) begin
        if (faces_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result transfer with nothing due: mask %b occ %b", $realtime,
                     out_data.face_mask, out_data.self_occupied);
        end else begin
          due = faces_due.pop_front();
          if (due.face_mask !== out_data.face_mask ||
              due.self_occupied !== out_data.self_occupied) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected mask %b occ %b, got mask %b occ %b",
                       $realtime, due.face_mask, due.self_occupied,
                       out_data.face_mask, out_data.self_occupied);
          end
        end
      end
      results_due <= faces_due.size();
    end
  end

endmodule

FILE: tb/sv/voxel_exposed_face_mask_unit_test.sv
// Top of the voxel exposed-face mask unit testbench: clock, reset, stimulus and verdict.
module voxel_exposed_face_mask_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vefm_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 700;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatch_count;
  int results_due;
  int stall_cycles;
  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  voxel_exposed_face_mask_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  vefm_face_checker face_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  task automatic push_item(input in_item_t item);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_write(input int x, input int y, input int z, input bit f);
    in_item_t item;
    item.command = CMD_WRITE;
    item.pos_x   = COORD_W'(x);
    item.pos_y   = COORD_W'(y);
    item.pos_z   = COORD_W'(z);
    item.fill    = f;
    push_item(item);
  endtask

  task automatic send_query(input int x, input int y, input int z, input bit f);
    in_item_t item;
    item.command = CMD_QUERY;
    item.pos_x   = COORD_W'(x);
    item.pos_y   = COORD_W'(y);
    item.pos_z   = COORD_W'(z);
    item.fill    = f;
    push_item(item);
  endtask

  function automatic int cluster_base();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 28;
      default: return $urandom_range(28);
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_item_t item;
    int       bx;
    int       by;
    int       bz;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty grid: every face exposed at both far corners
    send_query(0, 0, 0, 1'b1);
    send_query(31, 31, 31, 1'b0);
    // fully enclosed voxel
    send_write(5, 5, 5, 1'b1);
    send_write(4, 5, 5, 1'b1);
    send_write(6, 5, 5, 1'b1);
    send_write(5, 4, 5, 1'b1);
    send_write(5, 6, 5, 1'b1);
    send_write(5, 5, 4, 1'b1);
    send_write(5, 5, 6, 1'b1);
    send_query(5, 5, 5, 1'b0);
    send_query(6, 5, 5, 1'b1);
    // cleared voxel with occupied neighbours
    send_write(5, 5, 5, 1'b0);
    send_query(5, 5, 5, 1'b0);
    // boundary corners with inner neighbours filled
    send_write(1, 0, 0, 1'b1);
    send_write(0, 1, 0, 1'b1);
    send_write(0, 0, 1, 1'b1);
    send_write(0, 0, 0, 1'b1);
    send_query(0, 0, 0, 1'b0);
    send_write(30, 31, 31, 1'b1);
    send_write(31, 30, 31, 1'b1);
    send_write(31, 31, 30, 1'b1);
    send_query(31, 31, 31, 1'b1);

    bx = 0;
    by = 0;
    bz = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        bx = cluster_base();
        by = cluster_base();
        bz = cluster_base();
      end
      if (n == 200) hold_req = 1'b1;
      if (n == 400) begin
        in_valid <= 1'b0;
        wait (results_due == 0);
        @(negedge clk);
      end
      steady = (n >= 450 && n < 600);
      item.command = ($urandom_range(99) < 45) ? CMD_WRITE : CMD_QUERY;
      item.fill    = ($urandom_range(3) != 0);
      if ($urandom_range(4) == 0) begin
        item.pos_x = COORD_W'($urandom_range(31));
        item.pos_y = COORD_W'($urandom_range(31));
        item.pos_z = COORD_W'($urandom_range(31));
      end else begin
        item.pos_x = COORD_W'(bx + $urandom_range(3));
        item.pos_y = COORD_W'(by + $urandom_range(3));
        item.pos_z = COORD_W'(bz + $urandom_range(3));
      end
      push_item(item);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    wait (results_due == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
